// File: rtl/core/ordered_list_table_macros.svh
// ---------------------------------------------------------------------------
// Ordered list table assertion macros
// Shared property wrappers for the clocked checks in the list table RTL.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define OLT_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define OLT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/olt_pkg.sv
// ---------------------------------------------------------------------------
// Ordered list table package
// Command codes, sequencer states and fixed port widths.
// ---------------------------------------------------------------------------
package olt_pkg;

  localparam int unsigned POS_WIDTH   = 7;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FPOS_WIDTH  = 6;
  localparam int unsigned LEN_WIDTH   = 7;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_OVERWRITE = 3'd2,
    OP_READ      = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_SEARCH    = 3'd5,
    OP_CLEAR     = 3'd6
  } olt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STORE,
    ST_FINISH
  } olt_state_t;

endpackage

// File: rtl/core/olt_store.sv
// ---------------------------------------------------------------------------
// Ordered list table entry store
// Single-port-write, single-port-read RAM with a registered read.
// ---------------------------------------------------------------------------
module olt_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ordered_list_table.sv
// ---------------------------------------------------------------------------
// Ordered list table
// Ordered list of nonzero words kept in a RAM. A small sequencer moves or
// compares one entry per fetch and store step through a single read port.
// ---------------------------------------------------------------------------
// From accept, append, overwrite, clear and any rejected command go straight
// to the finish step; read takes one fetch and store step; insert and remove
// take one per entry from position to the end; a search one per entry seen.
// busy is low again in the done cycle, so the next start may be taken there.
// These steps are set by the RAM's one read port and its registered output.
// Reset (rst, synchronous) empties the list; stored words are not cleared.
// Results cannot be stalled: each is valid for the single cycle of done.
`include "ordered_list_table_macros.svh"

module ordered_list_table #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           opcode,
  input  logic [olt_pkg::POS_WIDTH-1:0]        position,
  input  logic [olt_pkg::VALUE_WIDTH-1:0]      element_value,
  output logic                                 done,
  output logic                                 status,
  output logic [olt_pkg::VALUE_WIDTH-1:0]      read_value,
  output logic                                 found,
  output logic [olt_pkg::FPOS_WIDTH-1:0]       found_position,
  output logic [olt_pkg::LEN_WIDTH-1:0]        list_length,
  output logic                                 is_empty
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > olt_pkg::POS_WIDTH) ? CW : olt_pkg::POS_WIDTH;

  olt_pkg::olt_state_t state, state_next;
  olt_pkg::olt_op_t    op_in, op_r;

  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            idx_p1, idx_m1;
  logic [CMPW-1:0]          pos_r;
  logic [CMPW-1:0]          pos_w, cnt_w;
  logic [ELEMENT_WIDTH-1:0] v_in, v_r;
  logic [ELEMENT_WIDTH-1:0] rv;
  logic [CW-1:0]            fpos_r;
  logic                     found_r;
  logic                     err_r;
  logic                     in_err, in_loop;
  logic                     v_zero, full;
  logic                     is_ins, hit, more;
  logic                     accept;

  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data, rd_data;

  olt_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign op_in  = olt_pkg::olt_op_t'(opcode);
  assign v_in   = ELEMENT_WIDTH'(element_value);
  assign v_zero = (v_in == '0);
  assign full   = (count == CW'(CAPACITY));
  assign pos_w  = CMPW'(position);
  assign cnt_w  = CMPW'(count);
  assign busy   = (state != olt_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign idx_p1 = idx + 1'b1;
  assign idx_m1 = idx - 1'b1;
  assign is_ins = (op_r inside {olt_pkg::OP_APPEND, olt_pkg::OP_INSERT});
  assign hit    = (op_r == olt_pkg::OP_SEARCH) && (rd_data == v_r);

  // Command check against the current length.
  always_comb begin
    in_err  = 1'b0;
    in_loop = 1'b0;
    unique case (op_in) inside
      olt_pkg::OP_APPEND: begin
        in_err = v_zero || full;
      end
      olt_pkg::OP_INSERT: begin
        in_err  = v_zero || full || (pos_w > cnt_w);
        in_loop = (cnt_w > pos_w);
      end
      olt_pkg::OP_OVERWRITE: begin
        in_err = v_zero || (pos_w >= cnt_w);
      end
      olt_pkg::OP_READ, olt_pkg::OP_REMOVE: begin
        in_err  = (pos_w >= cnt_w);
        in_loop = 1'b1;
      end
      olt_pkg::OP_SEARCH: begin
        in_loop = (count != '0);
      end
      olt_pkg::OP_CLEAR: begin
        in_err = 1'b0;
      end
      default: begin
        in_err = 1'b1;
      end
    endcase
  end

  // Whether another fetch follows the current store step.
  always_comb begin
    case (op_r)
      olt_pkg::OP_APPEND, olt_pkg::OP_INSERT: more = (CMPW'(idx_m1) > pos_r);
      olt_pkg::OP_REMOVE:                     more = (idx_p1 < count);
      olt_pkg::OP_SEARCH:                     more = !hit && (idx_p1 < count);
      default:                                more = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      olt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (!in_err && in_loop) ? olt_pkg::ST_FETCH : olt_pkg::ST_FINISH;
        end
      end
      olt_pkg::ST_FETCH: begin
        state_next = olt_pkg::ST_STORE;
      end
      olt_pkg::ST_STORE: begin
        state_next = more ? olt_pkg::ST_FETCH : olt_pkg::ST_FINISH;
      end
      olt_pkg::ST_FINISH: begin
        state_next = olt_pkg::ST_IDLE;
      end
      default: begin
        state_next = olt_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM port control. Insert moves entry idx-1 up to idx; remove moves entry
  // idx down to idx-1, except on the first step, which only picks up the word.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = is_ins ? idx_m1[AW-1:0] : idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      olt_pkg::ST_FETCH: begin
        rd_en = 1'b1;
      end
      olt_pkg::ST_STORE: begin
        if (is_ins) begin
          wr_en = 1'b1;
        end else if (op_r == olt_pkg::OP_REMOVE && CMPW'(idx) != pos_r) begin
          wr_en   = 1'b1;
          wr_addr = idx_m1[AW-1:0];
        end
      end
      olt_pkg::ST_FINISH: begin
        if (!err_r && (is_ins || op_r == olt_pkg::OP_OVERWRITE)) begin
          wr_en   = 1'b1;
          wr_addr = AW'(pos_r);
          wr_data = v_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (state == olt_pkg::ST_FINISH && !err_r) begin
      case (op_r)
        olt_pkg::OP_APPEND, olt_pkg::OP_INSERT: count_next = count + 1'b1;
        olt_pkg::OP_REMOVE:                     count_next = count - 1'b1;
        olt_pkg::OP_CLEAR:                      count_next = '0;
        default:                                count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olt_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == olt_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_in;
      v_r     <= v_in;
      err_r   <= in_err;
      rv      <= '0;
      found_r <= 1'b0;
      fpos_r  <= '0;
      unique case (op_in)
        olt_pkg::OP_APPEND: begin
          idx   <= count;
          pos_r <= cnt_w;
        end
        olt_pkg::OP_INSERT: begin
          idx   <= count;
          pos_r <= pos_w;
        end
        olt_pkg::OP_SEARCH: begin
          idx   <= '0;
          pos_r <= pos_w;
        end
        default: begin
          idx   <= CW'(position);
          pos_r <= pos_w;
        end
      endcase
    end else if (state == olt_pkg::ST_STORE) begin
      idx <= is_ins ? idx_m1 : idx_p1;
      if (op_r == olt_pkg::OP_READ ||
          (op_r == olt_pkg::OP_REMOVE && CMPW'(idx) == pos_r)) begin
        rv <= rd_data;
      end
      if (hit) begin
        found_r <= 1'b1;
        fpos_r  <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == olt_pkg::ST_FINISH) begin
      status         <= err_r;
      read_value     <= olt_pkg::VALUE_WIDTH'(rv);
      found          <= found_r;
      found_position <= olt_pkg::FPOS_WIDTH'(fpos_r);
      list_length    <= olt_pkg::LEN_WIDTH'(count_next);
      is_empty       <= (count_next == '0);
    end
  end

  `OLT_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while sequencer busy")
  `OLT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not start sequencer")
  `OLT_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `OLT_ASSERT_NOW(a_empty_match, done, is_empty == (count == '0), "empty flag disagrees with count")
  `OLT_ASSERT_NOW(a_found_ok, done && found, !status, "found flag set on an error result")

endmodule
